@@ src/tmrle_pkg.sv @@
// ---------------------------------------------------------------------------
// tmrle_pkg
// Shared constants and types of the threshold mono run-length encoder.
// ---------------------------------------------------------------------------
package tmrle_pkg;

  // pixel and frame position widths
  localparam int PIX_W      = 16;
  localparam int POS_W      = 20;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_GREY_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS   = 1'b1;

  // register reset values
  localparam logic [PIX_W-1:0] GREY_THRESHOLD_RST = 16'd33808;
  localparam logic [POS_W-1:0] FRAME_PIXELS_RST   = 20'd96000;

  // run colors
  localparam logic COLOR_DARK  = 1'b0;
  localparam logic COLOR_LIGHT = 1'b1;

  // result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // queue status seen by front and back
  typedef struct packed {
    logic room2;      // at least two free entries
    logic not_empty;  // at least one entry held
  } q_stat_t;

endpackage

@@ src/tmrle_if.sv @@
// ---------------------------------------------------------------------------
// tmrle interfaces
// Pixel input channel and run output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface tmrle_pix_if;
  import tmrle_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface tmrle_run_if #(
  parameter int RUN_W = 16
);
  logic             valid;
  logic             ready;
  logic [RUN_W-1:0] run_length;
  logic             run_color;
  logic             frame_end;

  modport source (output valid, output run_length, output run_color, output frame_end,
                  input ready);
  modport sink   (input valid, input run_length, input run_color, input frame_end,
                  output ready);
endinterface

@@ src/threshold_mono_run_length_encoder.sv @@
// ---------------------------------------------------------------------------
// threshold_mono_run_length_encoder
// Thresholds RGB565 pixels to dark/light and emits alternating run lengths.
// ---------------------------------------------------------------------------
//  channel   dir  payload                              handshake
//  pix_i     in   pixel[15:0]                          valid/ready
//  run_o     out  run_length, run_color, frame_end     valid/ready
//  cfg       in   cfg_idx_i, cfg_data_i[19:0]          cfg_we_i, no wait
//
// One pixel per clock while pix_i.ready is high: the front does the compare and run-count
// increment in the accepting cycle and pushes 0..2 runs into a 4-entry queue.
// A run passes from the queue through the output register of tmrle_back to run_o.
// pix_i.ready drops while the queue has fewer than two free entries.
// Reset restores the run state and both registers; no clearing pass.
// ---------------------------------------------------------------------------
module threshold_mono_run_length_encoder
  import tmrle_pkg::*;
#(
  parameter int RUN_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tmrle_pix_if.sink             pix_i,
  tmrle_run_if.source           run_o
);

  q_stat_t              q_stat;
  logic [1:0]           push_cnt;
  logic [RUN_WIDTH+1:0] push0;
  logic [RUN_WIDTH+1:0] push1;
  logic [RUN_WIDTH+1:0] head;
  logic                 pop;

  // classify and count
  tmrle_front #(.RUN_WIDTH(RUN_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .pixel_i    (pix_i.pixel),
    .q_stat_i   (q_stat),
    .push_cnt_o (push_cnt),
    .push0_o    (push0),
    .push1_o    (push1)
  );

  // decoupling queue
  tmrle_queue #(.RUN_WIDTH(RUN_WIDTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .pop_i      (pop),
    .head_o     (head),
    .q_stat_o   (q_stat)
  );

  // output register
  tmrle_back #(.RUN_WIDTH(RUN_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (run_o.valid),
    .out_ready_i  (run_o.ready),
    .run_length_o (run_o.run_length),
    .run_color_o  (run_o.run_color),
    .frame_end_o  (run_o.frame_end)
  );

endmodule

@@ src/tmrle_front.sv @@
// ---------------------------------------------------------------------------
// tmrle_front
// Accepts pixels, classifies them and tracks the open run; emits up to two
// run entries per pixel into the result queue.
// ---------------------------------------------------------------------------
module tmrle_front
  import tmrle_pkg::*;
#(
  parameter int RUN_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // pixel transaction
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [PIX_W-1:0]        pixel_i,
  // queue push side
  input  q_stat_t                 q_stat_i,
  output logic [1:0]              push_cnt_o,
  output logic [RUN_WIDTH+1:0]    push0_o,
  output logic [RUN_WIDTH+1:0]    push1_o
);

  localparam logic [RUN_WIDTH-1:0] RunLimit = {RUN_WIDTH{1'b1}};
  localparam logic [RUN_WIDTH-1:0] RunOne   = {{(RUN_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [POS_W-1:0]     PosOne   = {{(POS_W-1){1'b0}}, 1'b1};

  logic [PIX_W-1:0]     thresh_q;
  logic [POS_W-1:0]     frame_q;
  logic                 exp_q, exp_d;
  logic [RUN_WIDTH-1:0] run_q, run_d;
  logic [POS_W-1:0]     pos_q, pos_d;

  logic                 accept;
  logic                 color;
  logic                 last;
  logic                 chg;
  logic                 exp_a;
  logic [RUN_WIDTH-1:0] cnt_a;
  logic [RUN_WIDTH-1:0] cnt_b;
  logic                 sat;
  logic                 emit2;
  logic [RUN_WIDTH+1:0] ent_chg;
  logic [RUN_WIDTH+1:0] ent_run;

  assign in_ready_o = q_stat_i.room2;
  assign accept     = in_valid_i && in_ready_o;

  // classify and advance the open run
  always_comb begin
    color   = (pixel_i < thresh_q) ? COLOR_DARK : COLOR_LIGHT;
    last    = ((pos_q + PosOne) == frame_q);
    chg     = (color != exp_q);
    exp_a   = chg ? ~exp_q : exp_q;
    cnt_a   = chg ? '0 : run_q;
    cnt_b   = cnt_a + RunOne;
    sat     = (cnt_b == RunLimit);
    emit2   = sat || last;
    ent_chg = {run_q, exp_q, 1'b0};
    ent_run = {cnt_b, exp_a, last};
  end

  // order the entries for the queue
  always_comb begin
    push0_o    = chg ? ent_chg : ent_run;
    push1_o    = ent_run;
    push_cnt_o = 2'd0;
    if (accept) begin
      push_cnt_o = {1'b0, chg} + {1'b0, emit2};
    end
  end

  // next run state
  always_comb begin
    exp_d = exp_q;
    run_d = run_q;
    pos_d = pos_q;
    if (accept) begin
      if (last) begin
        exp_d = COLOR_DARK;
        run_d = '0;
        pos_d = '0;
      end else begin
        exp_d = sat ? ~exp_a : exp_a;
        run_d = sat ? '0 : cnt_b;
        pos_d = pos_q + PosOne;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= COLOR_DARK;
      run_q <= '0;
      pos_q <= '0;
    end else begin
      exp_q <= exp_d;
      run_q <= run_d;
      pos_q <= pos_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= GREY_THRESHOLD_RST;
      frame_q  <= FRAME_PIXELS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GREY_THRESHOLD: thresh_q <= cfg_data_i[PIX_W-1:0];
        REG_FRAME_PIXELS:   frame_q  <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/tmrle_queue.sv @@
// ---------------------------------------------------------------------------
// tmrle_queue
// Short result queue: up to two pushes and one pop per cycle.
// ---------------------------------------------------------------------------
module tmrle_queue
  import tmrle_pkg::*;
#(
  parameter int RUN_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  logic [RUN_WIDTH+1:0] push0_i,
  input  logic [RUN_WIDTH+1:0] push1_i,
  input  logic                 pop_i,
  output logic [RUN_WIDTH+1:0] head_o,
  output q_stat_t              q_stat_o
);

  localparam logic [QPTR_W-1:0] PtrOne  = {{(QPTR_W-1){1'b0}}, 1'b1};
  localparam logic [QCNT_W-1:0] RoomMax = QCNT_W'(QDEPTH - 2);

  logic [RUN_WIDTH+1:0] mem_q [QDEPTH];
  logic [QPTR_W-1:0]    wptr_q, wptr_d;
  logic [QPTR_W-1:0]    rptr_q, rptr_d;
  logic [QCNT_W-1:0]    cnt_q, cnt_d;

  assign head_o             = mem_q[rptr_q];
  assign q_stat_o.room2     = (cnt_q <= RoomMax);
  assign q_stat_o.not_empty = (cnt_q != '0);

  // pointer and fill level
  always_comb begin
    wptr_d = wptr_q + QPTR_W'(push_cnt_i);
    rptr_d = pop_i ? rptr_q + PtrOne : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(push_cnt_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr_q + PtrOne] <= push1_i;
    end
  end

endmodule

@@ src/tmrle_back.sv @@
// ---------------------------------------------------------------------------
// tmrle_back
// Drains the result queue into the output register of the run channel.
// ---------------------------------------------------------------------------
module tmrle_back
  import tmrle_pkg::*;
#(
  parameter int RUN_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  q_stat_t              q_stat_i,
  input  logic [RUN_WIDTH+1:0] head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RUN_WIDTH-1:0] run_length_o,
  output logic                 run_color_o,
  output logic                 frame_end_o
);

  logic                 valid_q, valid_d;
  logic [RUN_WIDTH+1:0] data_q;

  // refill the output register whenever it empties or is taken
  assign pop_o = q_stat_i.not_empty && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign run_length_o = data_q[RUN_WIDTH+1:2];
  assign run_color_o  = data_q[1];
  assign frame_end_o  = data_q[0];

endmodule

@@ src/tmrle_checker.sv @@
// ---------------------------------------------------------------------------
// tmrle_checker
// Port-level checks of the run channel, bound to the top level.
// ---------------------------------------------------------------------------
module tmrle_checker
  import tmrle_pkg::*;
#(
  parameter int RUN_WIDTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [RUN_WIDTH-1:0] run_length_i,
  input logic                 run_color_i,
  input logic                 frame_end_i
);

  logic out_acc;
  logic prev_color_q;
  logic prev_end_q;

  assign out_acc = out_valid_i && out_ready_i;

  // last delivered run; a frame boundary is assumed before the first one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_color_q <= COLOR_DARK;
      prev_end_q   <= 1'b1;
    end else if (out_acc) begin
      prev_color_q <= run_color_i;
      prev_end_q   <= frame_end_i;
    end
  end

  // a stalled run stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("run valid dropped while stalled");

  // a stalled run keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(run_length_i) && $stable(run_color_i) && $stable(frame_end_i))
    else $error("run payload changed while stalled");

  // a frame's closing run always holds at least its last pixel
  a_end_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> run_length_i != '0)
    else $error("zero-length run closes a frame");

  // colors alternate within a frame and every frame opens dark
  a_alternate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (prev_end_q ? (run_color_i == COLOR_DARK)
                            : (run_color_i != prev_color_q)))
    else $error("run color out of sequence");

endmodule

bind threshold_mono_run_length_encoder tmrle_checker #(.RUN_WIDTH(RUN_WIDTH)) u_tmrle_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (run_o.valid),
  .out_ready_i  (run_o.ready),
  .run_length_i (run_o.run_length),
  .run_color_i  (run_o.run_color),
  .frame_end_i  (run_o.frame_end)
);

@@ tb/tb_threshold_mono_run_length_encoder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_threshold_mono_run_length_encoder
// Streams pixels into the encoder under random idling and back-pressure and
// compares every run transaction against a cycle-free model of the
// dark/light run state, including zero-length runs, single-pixel frames and
// frame-size changes.
// ---------------------------------------------------------------------------
import tmrle_pkg::*;

// expected runs, worked out per accepted pixel, and the checks against them
class run_scoreboard #(
  parameter int RUN_W = 16
);
  typedef struct packed {
    logic [RUN_W-1:0] len;
    logic             color;
    logic             last;
  } run_t;

  logic [PIX_W-1:0] grey_thr;
  logic [POS_W-1:0] frame_len;
  logic             want_color;
  logic [RUN_W-1:0] run_cnt;
  logic [POS_W-1:0] pix_pos;
  run_t             runs_due[$];

  int errors;
  int pixels_seen;
  int runs_checked;
  int frames_closed;
  int saturated_runs;
  int zero_runs;

  function new();
    grey_thr   = GREY_THRESHOLD_RST;
    frame_len  = FRAME_PIXELS_RST;
    want_color = COLOR_DARK;
    run_cnt    = '0;
    pix_pos    = '0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_GREY_THRESHOLD: grey_thr = val[PIX_W-1:0];
      REG_FRAME_PIXELS:   frame_len = val[POS_W-1:0];
      default: ;
    endcase
  endfunction

  function void push_run(logic [RUN_W-1:0] len, logic color, logic last);
    run_t r;
    r.len   = len;
    r.color = color;
    r.last  = last;
    runs_due.push_back(r);
    if (len == '0) zero_runs++;
    if (len == '1) saturated_runs++;
  endfunction

  // advance the run state by one accepted pixel
  function void note_pixel(logic [PIX_W-1:0] px);
    logic color;
    logic last;
    logic [POS_W-1:0] next_pos;
    color    = (px < grey_thr) ? COLOR_DARK : COLOR_LIGHT;
    next_pos = pix_pos + 1'b1;
    last     = (next_pos == frame_len);
    pixels_seen++;

    // color change closes the open run, possibly empty
    if (color != want_color) begin
      push_run(run_cnt, want_color, 1'b0);
      want_color = ~want_color;
      run_cnt    = '0;
    end

    run_cnt = run_cnt + 1'b1;

    // saturated run goes out at once and flips the color
    if (run_cnt == '1) begin
      push_run(run_cnt, want_color, last);
      want_color = ~want_color;
      run_cnt    = '0;
    end else if (last) begin
      push_run(run_cnt, want_color, 1'b1);
    end

    if (last) begin
      want_color = COLOR_DARK;
      run_cnt    = '0;
      pix_pos    = '0;
      frames_closed++;
    end else begin
      pix_pos = next_pos;
    end
  endfunction

  function void check_run(logic [RUN_W-1:0] len, logic color, logic last);
    run_t due;
    runs_checked++;
    if (runs_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected run: expected none, actual len=%0d color=%0d frame_end=%0d",
               $time, len, color, last);
      return;
    end
    due = runs_due.pop_front();
    if (due.len !== len) begin
      errors++;
      $display("%0t: run_length mismatch: expected %0d, actual %0d", $time, due.len, len);
    end
    if (due.color !== color) begin
      errors++;
      $display("%0t: run_color mismatch: expected %0d, actual %0d", $time, due.color, color);
    end
    if (due.last !== last) begin
      errors++;
      $display("%0t: frame_end mismatch: expected %0d, actual %0d", $time, due.last, last);
    end
  endfunction

  function int pending();
    return runs_due.size();
  endfunction
endclass

module tb_threshold_mono_run_length_encoder;

  localparam int RUN_W          = 16;
  localparam int RANDOM_PIXELS  = 1530;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF       = 400;
  localparam int IDLE_PCT       = 19;

  // threshold boundaries and every pixel bit in both states
  localparam logic [PIX_W-1:0] EDGE_PIXELS [8] = '{
    16'h0000, 16'h0000, 16'hFFFF, 16'd33808, 16'd33807, 16'd33807, 16'hAAAA, 16'h5555
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tmrle_pix_if                    pix_if ();
  tmrle_run_if #(.RUN_W(RUN_W))   run_if ();

  threshold_mono_run_length_encoder #(
    .RUN_WIDTH(RUN_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix_i     (pix_if.sink),
    .run_o     (run_if.source)
  );

  run_scoreboard #(RUN_W) sb;

  int src_idle_pct;
  int snk_idle_pct;
  int stall_left;
  int quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run receiver: random idling, plus a long hold-off on request
  initial begin
    run_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        run_if.ready <= 1'b0;
        stall_left--;
      end else begin
        run_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // check every accepted run transaction
  always @(posedge clk_i) begin
    if (rst_ni && run_if.valid && run_if.ready) begin
      sb.check_run(run_if.run_length, run_if.run_color, run_if.frame_end);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (run_if.valid && run_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // pixel of the wanted color (light when the threshold is zero), sometimes right at the threshold
  function automatic logic [PIX_W-1:0] pick_pixel(logic color, logic [PIX_W-1:0] thr);
    logic at_edge;
    at_edge = ($urandom_range(7) == 0);
    if (color == COLOR_DARK && thr != '0) begin
      return at_edge ? thr - 1'b1 : PIX_W'($urandom_range(0, thr - 1));
    end
    return at_edge ? thr : PIX_W'($urandom_range(thr, 16'hFFFF));
  endfunction

  // offer one pixel and wait for its transaction
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    sb.note_pixel(px);
  endtask

  // stop offering and let every expected run come out
  task automatic wait_drain();
    pix_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [PIX_W-1:0] thr, input logic [POS_W-1:0] frame);
    wait_drain();
    cfg_write(REG_GREY_THRESHOLD, CFG_DATA_W'(thr));
    cfg_write(REG_FRAME_PIXELS, CFG_DATA_W'(frame));
  endtask

  // stimulus
  initial begin
    logic [PIX_W-1:0] thr;
    logic [POS_W-1:0] frame;
    logic             stripe_color;
    logic             striped;
    int               stripe_left;
    int               burst;
    int               phase;
    int               n_random;

    sb           = new();
    src_idle_pct = IDLE_PCT;
    snk_idle_pct = IDLE_PCT;
    stall_left   = 0;
    stripe_left  = 0;
    stripe_color = COLOR_DARK;
    rst_ni       = 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_GREY_THRESHOLD;
    cfg_data     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds, color changes inside one long frame
    foreach (EDGE_PIXELS[i]) send_pixel(EDGE_PIXELS[i]);

    // zero threshold: all light, frame shortened mid-frame
    reconfigure(16'h0000, sb.pix_pos + 20'd4);
    send_pixel(16'h0000);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);

    // single-pixel frames at the top threshold, then two- and three-pixel frames
    reconfigure(16'hFFFF, 20'd1);
    send_pixel(16'hFFFE);
    send_pixel(16'hFFFF);
    reconfigure(16'hFFFF, 20'd2);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    reconfigure(16'h0001, 20'd3);
    repeat (3) send_pixel(16'h0000);

    // random phases with fresh settings
    phase    = 0;
    n_random = 0;
    while (n_random < RANDOM_PIXELS) begin
      case ($urandom_range(7))
        0:       thr = 16'h0000;
        1:       thr = 16'hFFFF;
        2:       thr = GREY_THRESHOLD_RST;
        default: thr = PIX_W'($urandom());
      endcase
      case ($urandom_range(9))
        0:       frame = sb.pix_pos + 1'b1;
        1:       frame = 20'd0;
        2:       frame = 20'hFFFFF;
        3:       frame = sb.pix_pos + POS_W'($urandom_range(100, 400));
        default: frame = sb.pix_pos + POS_W'($urandom_range(1, 40));
      endcase
      reconfigure(thr, frame);

      src_idle_pct = (phase % 4 == 1) ? 0 : IDLE_PCT;
      snk_idle_pct = src_idle_pct;
      burst        = $urandom_range(20, 120);
      // long receiver hold-off while pixels keep coming
      if (phase == 2) begin
        src_idle_pct = 0;
        stall_left   = HOLD_OFF;
        burst        = 150;
      end

      striped = ($urandom_range(3) != 0);
      repeat (burst) begin
        if (stripe_left == 0) begin
          stripe_left  = $urandom_range(1, 12);
          stripe_color = 1'($urandom_range(1));
        end
        stripe_left--;
        send_pixel(striped ? pick_pixel(stripe_color, thr) : PIX_W'($urandom()));
        n_random++;
      end
      phase++;
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d pixels in %0d random phases, %0d runs checked, %0d frames closed",
             sb.pixels_seen, phase, sb.runs_checked, sb.frames_closed);
    $display("saw %0d saturated runs and %0d zero-length runs",
             sb.saturated_runs, sb.zero_runs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
